// ===== rtl/core/double_ended_queue_defines.svh =====
// Assertion macros for the deque core.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words, DEPTH entries.
// Input channel (i_in_valid / o_in_stall / i_in_data): one command per transfer,
// push front, push rear, pop front or pop rear.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result per
// command, in command order: popped word (0 unless a pop succeeded), status
// (ok, full on push, empty on pop) and the occupancy after the command.
// The result is registered and appears in the cycle after the command transfer.
// Throughput: one command per cycle while o_in_stall is low. Every successful
// command either writes one entry or reads one entry of the single-port-per-direction
// word memory, and pointers and count update in the same cycle, so a pop right
// after a push to the same entry reads the new word without forwarding.
// Failed commands change nothing.
// Reset: head, tail and count go to zero, no result is pending; memory
// contents are not cleared.
// Stall: while a result waits under i_out_stall, o_in_stall is raised and no
// command is taken; the result register and its read data hold.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  deq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output deq_pkg::t_out_item o_out_data
);

    `include "double_ended_queue_defines.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    logic          r_pop_ok, n_pop_ok;
    deq_pkg::t_status r_status, n_status;
    logic [deq_pkg::DATA_W-1:0] r_rd_data;

    logic          w_acc;
    logic          w_full;
    logic          w_empty;
    logic [PW-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic          w_wr_en, w_rd_en;
    logic [PW-1:0] w_wr_addr, w_rd_addr;
    logic [31:0]   w_cnt32;

    assign o_in_stall = r_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_head_inc = (r_head == LAST) ? '0 : r_head + PW'(1);
    assign w_head_dec = (r_head == '0) ? LAST : r_head - PW'(1);
    assign w_tail_inc = (r_tail == LAST) ? '0 : r_tail + PW'(1);
    assign w_tail_dec = (r_tail == '0) ? LAST : r_tail - PW'(1);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_pop_ok  = 1'b0;
        n_status  = deq_pkg::ST_OK;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_wr_addr = r_tail;
        w_rd_addr = r_head;
        unique case (i_in_data.cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
                w_wr_addr = w_head_dec;
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = w_acc;
                    n_head  = w_head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::CMD_PUSH_REAR: begin
                w_wr_addr = r_tail;
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_wr_en = w_acc;
                    n_tail  = w_tail_inc;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                w_rd_addr = r_head;
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_rd_en  = w_acc;
                    n_pop_ok = 1'b1;
                    n_head   = w_head_inc;
                    n_count  = r_count - CW'(1);
                end
            end
            deq_pkg::CMD_POP_REAR: begin
                w_rd_addr = w_tail_dec;
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_rd_en  = w_acc;
                    n_pop_ok = 1'b1;
                    n_tail   = w_tail_dec;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_in_data.push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pop_ok <= n_pop_ok;
            r_status <= n_status;
        end
    end

    // r_count always reflects the command whose result is on display
    assign w_cnt32                = 32'(r_count);
    assign o_out_valid            = r_valid;
    assign o_out_data.pop_value   = r_pop_ok ? r_rd_data : '0;
    assign o_out_data.status      = r_status;
    assign o_out_data.occupancy   = w_cnt32[deq_pkg::OCC_W-1:0];

    `DEQ_ASSERT_NOW(a_ptr_meet, (w_empty || w_full), (r_head == r_tail), "pointers disagree with count")
    `DEQ_ASSERT_NEXT(a_push_cnt, (w_acc && !w_full && (i_in_data.cmd == deq_pkg::CMD_PUSH_FRONT || i_in_data.cmd == deq_pkg::CMD_PUSH_REAR)), (r_count == $past(r_count) + CW'(1)), "push did not grow count")
    `DEQ_ASSERT_NOW(a_empty_res, (o_out_valid && r_status == deq_pkg::ST_EMPTY), (w_empty && !r_pop_ok), "empty status with stored words")
    `DEQ_ASSERT_NOW(a_full_res, (o_out_valid && r_status == deq_pkg::ST_FULL), (w_full && !r_pop_ok), "full status below capacity")

endmodule

// ===== test/double_ended_queue_tb.sv =====
module double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int ITEMS     = 1350;
    localparam int MAX_GAP   = 13;
    localparam int LONG_HOLD = 150;
    localparam int TAIL_WAIT = 8;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        t_cmd              cmd;
        logic [DATA_W-1:0] value;
        int                reps;
        bit                pinned;
        t_out_item         want;
    } t_row;

    typedef struct {
        bit        pinned;
        t_out_item want;
    } t_tag;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    logic [DATA_W-1:0] model_slots [DEPTH];
    int model_head  = 0;
    int model_tail  = 0;
    int model_count = 0;

    t_out_item pending_results [$];
    t_tag      sent_tags [$];

    int mismatches   = 0;
    int cycles       = 0;
    int holds_wanted = 0;
    int holds_served = 0;
    int send_calm    = 0;
    int recv_calm    = 0;

    double_ended_queue #(.DEPTH(DEPTH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_out_item deque_result(t_in_item it);
        t_out_item r;
        r.pop_value = '0;
        r.status    = ST_OK;
        if (it.cmd == CMD_PUSH_FRONT || it.cmd == CMD_PUSH_REAR) begin
            if (model_count >= DEPTH) begin
                r.status = ST_FULL;
            end else if (it.cmd == CMD_PUSH_FRONT) begin
                model_head = (model_head + DEPTH - 1) % DEPTH;
                model_slots[model_head] = it.push_value;
                model_count++;
            end else begin
                model_slots[model_tail] = it.push_value;
                model_tail = (model_tail + 1) % DEPTH;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                r.status = ST_EMPTY;
            end else if (it.cmd == CMD_POP_FRONT) begin
                r.pop_value = model_slots[model_head];
                model_head = (model_head + 1) % DEPTH;
                model_count--;
            end else begin
                model_tail = (model_tail + DEPTH - 1) % DEPTH;
                r.pop_value = model_slots[model_tail];
                model_count--;
            end
        end
        r.occupancy = OCC_W'(model_count);
        return r;
    endfunction

    // zero gaps come in stretches so back-to-back transfers also get exercised
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // mode 0 mostly pushes, mode 1 mostly pops, mode 2 is even
    function automatic t_in_item make_cmd(int mode);
        t_in_item it;
        int       roll;
        bit       push;
        roll = $urandom_range(0, 9);
        push = (mode == 0) ? (roll < 8) : (mode == 1) ? (roll < 2) : (roll < 5);
        if (push) begin
            it.cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        end else begin
            it.cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
        end
        case ($urandom_range(0, 7))
            0: it.push_value = 32'h7FFF_FFFF;
            1: it.push_value = 32'h8000_0000;
            2: it.push_value = '0;
            3: it.push_value = '1;
            default: it.push_value = $urandom;
        endcase
        return it;
    endfunction

    task automatic flag_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_cmd(t_in_item it, bit pinned, t_out_item want);
        int   gap;
        t_tag tag;
        gap = draw_gap(send_calm);
        tag.pinned = pinned;
        tag.want   = want;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sent_tags.push_back(tag);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!(in_valid && !o_in_stall));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_tag      tag;
        if (i_rst_n && in_valid && !o_in_stall) begin
            want = deque_result(in_data);
            tag  = sent_tags.pop_front();
            if (tag.pinned) begin
                want = tag.want;
            end
            pending_results.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("transfer with nothing pending", o_out_data.pop_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.pop_value !== want.pop_value) begin
                    flag_mismatch("pop_value", o_out_data.pop_value, want.pop_value);
                end
                if (o_out_data.status !== want.status) begin
                    flag_mismatch("status", o_out_data.status, want.status);
                end
                if (o_out_data.occupancy !== want.occupancy) begin
                    flag_mismatch("occupancy", o_out_data.occupancy, want.occupancy);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
    end

    initial begin : receiver
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (holds_served < holds_wanted) begin
                holds_served++;
                gap = LONG_HOLD;
            end else begin
                gap = draw_gap(recv_calm);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !out_stall));
        end
    end

    initial begin : stimulus
        t_row      script [14];
        t_in_item  it;
        t_out_item none;
        int        sent;
        int        bursts;
        int        mode;
        int        len;
        none   = '0;
        sent   = 0;
        bursts = 0;
        // empty pops, extreme words, both pointers wrapping backward and
        // forward, then fill to the brim and push into a full deque
        script = '{
            '{CMD_POP_FRONT,  32'h0000_0000, 1, 1'b1, '{32'h0,         ST_EMPTY, 5'd0}},
            '{CMD_POP_REAR,   32'h0000_0000, 1, 1'b1, '{32'h0,         ST_EMPTY, 5'd0}},
            '{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1'b1, '{32'h0,         ST_OK,    5'd1}},
            '{CMD_PUSH_REAR,  32'h8000_0000, 1, 1'b1, '{32'h0,         ST_OK,    5'd2}},
            '{CMD_POP_FRONT,  32'h0000_0000, 1, 1'b1, '{32'h7FFF_FFFF, ST_OK,    5'd1}},
            '{CMD_POP_REAR,   32'hFFFF_FFFF, 1, 1'b1, '{32'h8000_0000, ST_OK,    5'd0}},
            '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b0, '{32'h0,         ST_OK,    5'd0}},
            '{CMD_POP_REAR,   32'h0000_0000, 1, 1'b0, '{32'h0,         ST_OK,    5'd0}},
            '{CMD_PUSH_REAR,  32'h0000_0000, 1, 1'b0, '{32'h0,         ST_OK,    5'd0}},
            '{CMD_POP_FRONT,  32'h0000_0000, 1, 1'b0, '{32'h0,         ST_OK,    5'd0}},
            '{CMD_PUSH_FRONT, 32'h0000_1000, 8, 1'b0, '{32'h0,         ST_OK,    5'd0}},
            '{CMD_PUSH_REAR,  32'h1234_0000, 8, 1'b0, '{32'h0,         ST_OK,    5'd0}},
            '{CMD_PUSH_FRONT, 32'h5555_5555, 1, 1'b1, '{32'h0,         ST_FULL,  5'd16}},
            '{CMD_PUSH_REAR,  32'hAAAA_AAAA, 1, 1'b1, '{32'h0,         ST_FULL,  5'd16}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                it.cmd        = script[r].cmd;
                it.push_value = script[r].value + k;
                send_cmd(it, script[r].pinned, script[r].want);
                sent++;
            end
        end

        // bursts biased toward filling, draining or neither; some hold the output
        // for a long stretch while commands keep coming back to back
        while (sent < ITEMS) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(8, 40);
            if (bursts == 0 || $urandom_range(0, 11) == 0) begin
                holds_wanted++;
                send_calm = len;
            end
            bursts++;
            repeat (len) begin
                send_cmd(make_cmd(mode), 1'b0, none);
                sent++;
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/double_ended_queue.sv
test/double_ended_queue_tb.sv
